[hdl/sha256_pkg.sv]
// Shared types, constants and round functions for the SHA-256 core.
package sha256_pkg;

  localparam int unsigned BlkWords = 16;
  localparam int unsigned Rounds   = 64;

  typedef logic [31:0] word_t;

  // One block handed from the packer to the compression engine.
  typedef struct packed {
    logic [BlkWords*32-1:0] words;     // word 0 in the top bits
    logic                   final_blk; // emit the digest after this block
  } blk_req_t;

  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_ROUND,
    ENG_ADD,
    ENG_EMIT
  } eng_state_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0:    r = 32'h6a09e667;
      3'd1:    r = 32'hbb67ae85;
      3'd2:    r = 32'h3c6ef372;
      3'd3:    r = 32'ha54ff53a;
      3'd4:    r = 32'h510e527f;
      3'd5:    r = 32'h9b05688c;
      3'd6:    r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned k);
    return (v >> k) | (v << (32 - k));
  endfunction

endpackage

[hdl/sha256_packer.sv]
// Front end: packs bytes into blocks and builds the padding blocks.
module sha256_packer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 stall,
  input  logic [7:0]           msg_byte,
  input  logic                 no_byte,
  input  logic                 msg_last,
  output logic                 blk_valid,
  input  logic                 blk_stall,
  output sha256_pkg::blk_req_t blk
);
  import sha256_pkg::*;

  // Block buffer; bytes are placed at count[5:0].
  logic [7:0]  buf_bytes [64];
  logic [60:0] count;
  // Pending padding work after a message end
  logic        pad_pend;   // still have padding blocks to send
  logic        pad_two;    // first of two padding blocks
  logic [60:0] pad_len;
  logic [5:0]  pad_pos;    // position of the 0x80 marker
  logic        full_pend;  // a full data block waits to be sent
  logic        pad_act;    // padding block is the one on offer

  logic        acc;
  logic        has_byte;
  logic [5:0]  pos;
  logic        blk_fire;

  assign has_byte = !no_byte;
  assign pos      = count[5:0];
  assign stall    = full_pend || pad_pend;
  assign acc      = valid && !stall;
  assign blk_valid = full_pend || pad_pend;
  assign blk_fire = blk_valid && !blk_stall;
  // a full data block always goes out ahead of the padding
  assign pad_act  = pad_pend && !full_pend;

  // Build outgoing block from the buffer plus padding rules.
  always_comb begin
    logic [63:0] bits;
    logic [7:0]  b;
    bits = {pad_len, 3'b000};
    blk.final_blk = pad_act && !pad_two;
    for (int i = 0; i < 64; i++) begin
      if (!pad_act) begin
        b = buf_bytes[i];
      end else if (pad_two || pad_pos < 6'd56) begin
        // block holding the marker
        if (6'(i) < pad_pos) b = buf_bytes[i];
        else if (6'(i) == pad_pos) b = 8'h80;
        else b = 8'h00;
        if (!pad_two && i >= 56) b = bits[(63 - i) * 8 +: 8];
      end else begin
        b = 8'h00;
      end
      if (pad_act && !pad_two && pad_pos >= 6'd56 && i >= 56) b = bits[(63 - i) * 8 +: 8];
      blk.words[(63 - i) * 8 +: 8] = b;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && has_byte) buf_bytes[pos] <= msg_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pad_pend  <= 1'b0;
      pad_two   <= 1'b0;
      full_pend <= 1'b0;
    end else begin
      if (acc) begin
        logic [60:0] cnt_n;
        cnt_n = has_byte ? count + 61'd1 : count;
        if (has_byte && pos == 6'd63) full_pend <= 1'b1;
        if (msg_last) begin
          pad_pend <= 1'b1;
          pad_len  <= cnt_n;
          pad_pos  <= cnt_n[5:0];
          pad_two  <= (cnt_n[5:0] >= 6'd56);
          count    <= '0;
        end else begin
          count <= cnt_n;
        end
      end
      if (blk_fire) begin
        if (full_pend) full_pend <= 1'b0;
        else if (pad_two) pad_two <= 1'b0;
        else pad_pend <= 1'b0;
      end
    end
  end

  // The final block never fires while a full data block is still pending
  assert property (@(posedge clk) disable iff (rst) blk_fire && blk.final_blk |-> !full_pend)
    else $error("final block issued ahead of data block");
  assert property (@(posedge clk) disable iff (rst) pad_two |-> pad_pend)
    else $error("two-block pad flag without pending pad");
  assert property (@(posedge clk) disable iff (rst) acc |-> !blk_valid)
    else $error("accepted byte while block pending");
endmodule

[hdl/sha256_queue.sv]
// Two-entry queue carrying blocks from the packer to the engine.
module sha256_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha256_pkg::blk_req_t in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha256_pkg::blk_req_t out_data
);
  import sha256_pkg::*;

  blk_req_t   mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic       push, pop;

  assign in_stall  = (fill == 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign push = in_valid && !in_stall;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue overfill");
  assert property (@(posedge clk) disable iff (rst) push && !pop |=> fill != 2'd0)
    else $error("queue lost entry");
  assert property (@(posedge clk) disable iff (rst)
    (fill == 2'd0 || fill == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointer mismatch");
endmodule

[hdl/sha256_engine.sv]
// Back end: 64-round compression, one round per cycle, and digest output.
module sha256_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 blk_valid,
  output logic                 blk_stall,
  input  sha256_pkg::blk_req_t blk,
  output logic                 valid,
  input  logic                 stall,
  output logic [31:0]          digest_word,
  output logic [2:0]           word_index,
  output logic                 digest_last
);
  import sha256_pkg::*;

  eng_state_t state, state_next;
  word_t      h    [8];
  word_t      wv   [8];
  word_t      win  [16];
  logic [5:0] rnd;
  logic [2:0] idx;
  logic       fin;
  logic       take;
  word_t      wt, x15, x2, s0, s1, t1, t2, wnew;

  assign take = (state == ENG_IDLE) && blk_valid;

  always_comb begin
    state_next = state;
    case (state)
      ENG_IDLE:  if (blk_valid) state_next = ENG_ROUND;
      ENG_ROUND: if (rnd == 6'd63) state_next = ENG_ADD;
      ENG_ADD:   state_next = fin ? ENG_EMIT : ENG_IDLE;
      ENG_EMIT:  if (!stall && idx == 3'd7) state_next = ENG_IDLE;
      default:   state_next = ENG_IDLE;
    endcase
  end

  always_comb begin
    blk_stall   = (state != ENG_IDLE);
    valid       = (state == ENG_EMIT);
    digest_word = h[idx];
    word_index  = idx;
    digest_last = (idx == 3'd7);
  end

  // Window kept as shift line: win[0] is W[t].
  always_comb begin
    x15  = win[1];
    x2   = win[14];
    s0   = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    s1   = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    wnew = win[0] + s0 + win[9] + s1;
    wt   = win[0];
    t1 = wv[7] + (rotr(wv[4], 6) ^ rotr(wv[4], 11) ^ rotr(wv[4], 25))
       + ((wv[4] & wv[5]) ^ (~wv[4] & wv[6])) + round_k(rnd) + wt;
    t2 = (rotr(wv[0], 2) ^ rotr(wv[0], 13) ^ rotr(wv[0], 22))
       + ((wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]));
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < 16; i++) win[i] <= blk.words[(15 - i) * 32 +: 32];
      for (int i = 0; i < 8; i++) wv[i] <= h[i];
    end else if (state == ENG_ROUND) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
      win[15] <= wnew;
      wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
      wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
      rnd   <= '0;
      idx   <= '0;
      fin   <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
    end else begin
      state <= state_next;
      if (take) begin
        fin <= blk.final_blk;
        rnd <= '0;
      end
      if (state == ENG_ROUND) rnd <= rnd + 6'd1;
      if (state == ENG_ADD) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + wv[i];
        idx <= '0;
      end
      if (state == ENG_EMIT && !stall) begin
        idx <= idx + 3'd1;
        if (idx == 3'd7)
          for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) state == ENG_ROUND && rnd == 6'd63 |=> state == ENG_ADD)
    else $error("round count overrun");
  assert property (@(posedge clk) disable iff (rst) valid && stall |=> valid && $stable(idx))
    else $error("digest word dropped under stall");
  assert property (@(posedge clk) disable iff (rst) state == ENG_ADD && !fin |=> !valid)
    else $error("digest emitted for non-final block");
endmodule

[hdl/sha256_hash_core.sv]
// SHA-256 core top level: byte packer, block queue and compression engine.
//
// Input channel: one request per cycle carries msg_byte, or none when
// no_byte is set; msg_last closes the message after that request.
// Output channel: on each message end the core sends eight requests,
// digest_word with word_index 0..7, digest_last on word 7.
// Bytes are taken at one per cycle while the packer buffer fills; a full
// block is handed to a two-entry queue, and input is stalled until the
// queue takes it. The engine runs one round per cycle; each block passes
// through load, 64 rounds and the final add, so the sustained rate is set
// by the round loop at roughly one byte per cycle for long messages.
// After msg_last the packer issues one or two padding blocks; the first
// digest word appears once the last block has passed through its rounds
// and the final add. A stall on the output holds the current word; the
// engine and then the queue and input back up behind it.
// Reset clears counts and loads the initial hash; no clearing pass.
module sha256_hash_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  msg_byte,
  input  logic        no_byte,
  input  logic        msg_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        digest_last
);
  import sha256_pkg::*;

  logic     pk_valid, pk_stall, q_valid, q_stall;
  blk_req_t pk_blk, q_blk;

  sha256_packer u_packer (
    .clk, .rst, .valid(in_valid), .stall(in_stall),
    .msg_byte, .no_byte, .msg_last,
    .blk_valid(pk_valid), .blk_stall(pk_stall), .blk(pk_blk)
  );

  sha256_queue u_queue (
    .clk, .rst, .in_valid(pk_valid), .in_stall(pk_stall), .in_data(pk_blk),
    .out_valid(q_valid), .out_stall(q_stall), .out_data(q_blk)
  );

  sha256_engine u_engine (
    .clk, .rst, .blk_valid(q_valid), .blk_stall(q_stall), .blk(q_blk),
    .valid(out_valid), .stall(out_stall),
    .digest_word, .word_index, .digest_last
  );
endmodule

[tb/sha256_hash_core_tb.sv]
// Testbench for the SHA-256 byte-stream core: random and directed messages against a digest model.
`timescale 1ns / 1ps

module sha256_hash_core_tb;
  import sha256_pkg::*;

  localparam time ClkPeriod = 12ns;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  msg_byte;
  logic        no_byte;
  logic        msg_last;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  int unsigned err_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_cycles;
  int unsigned n_sent;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_out_t;

  sha256_hash_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .msg_byte(msg_byte), .no_byte(no_byte), .msg_last(msg_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .digest_word(digest_word), .word_index(word_index), .digest_last(digest_last)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("tb: mismatch %s got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  class digest_scoreboard;
    logic [31:0] chain[8];
    logic [31:0] blk[16];
    logic [60:0] nbytes;
    digest_out_t pending[$];

    function new();
      for (int i = 0; i < 8; i++) chain[i] = init_val(i);
      nbytes = '0;
    endfunction

    static function logic [31:0] init_val(input int i);
      logic [31:0] iv[8];
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return iv[i];
    endfunction

    static function logic [31:0] ror(input logic [31:0] v, input int k);
      return (v >> k) | (v << (32 - k));
    endfunction

    function void compress();
      logic [31:0] w[64];
      logic [31:0] v[8];
      logic [31:0] t1, t2;
      for (int t = 0; t < 16; t++) w[t] = blk[t];
      for (int t = 16; t < 64; t++)
        w[t] = w[t-16] + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
             + w[t-7] + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int t = 0; t < 64; t++) begin
        t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(t[5:0]) + w[t];
        t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] += v[i];
    endfunction

    // big-endian byte insert; later bytes of the word are cleared
    function void place(input int pos, input logic [7:0] b);
      int wi;
      int sh;
      wi = pos / 4;
      sh = (3 - pos % 4) * 8;
      if (pos % 4 == 0) blk[wi] = '0;
      else blk[wi] = blk[wi] & (32'hffffffff << (sh + 8));
      blk[wi] |= 32'(b) << sh;
    endfunction

    function void note_request(input logic [7:0] b, input logic nb, input logic lst);
      int pos;
      logic [63:0] bits;
      digest_out_t d;
      if (!nb) begin
        pos = int'(nbytes[5:0]);
        place(pos, b);
        nbytes = nbytes + 61'd1;
        if (pos == 63) compress();
      end
      if (!lst) return;
      pos = int'(nbytes[5:0]);
      place(pos, 8'h80);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      bits = {nbytes, 3'b000};
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = chain[i];
        d.idx = i[2:0];
        d.last = (i == 7);
        pending.push_back(d);
        chain[i] = init_val(i);
      end
      nbytes = '0;
    endfunction

    task check_digest(input logic [31:0] wd, input logic [2:0] ix, input logic lst);
      digest_out_t e;
      if (pending.size() == 0) begin
        report_mismatch("unexpected word", wd, 32'd0);
        return;
      end
      e = pending.pop_front();
      if (wd !== e.word) report_mismatch("digest_word", wd, e.word);
      if (ix !== e.idx) report_mismatch("word_index", 32'(ix), 32'(e.idx));
      if (lst !== e.last) report_mismatch("digest_last", 32'(lst), 32'(e.last));
    endtask
  endclass

  digest_scoreboard sb;

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  initial begin
    #(ClkPeriod * 4000000);
    $display("tb: failure");
    $finish;
  end

  // receiver side: random stall, with an optional long hold-off
  initial begin
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_digest(digest_word, word_index, digest_last);
  end

  // one request; valid stays high across back-to-back requests
  task automatic send_request(input logic [7:0] b, input logic nb, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    msg_byte <= b;
    no_byte  <= nb;
    msg_last <= lst;
    do @(posedge clk); while (in_stall);
    sb.note_request(b, nb, lst);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len, input bit rnd_empty);
    for (int i = 0; i < len; i++) begin
      if (rnd_empty && $urandom_range(9) == 0)
        send_request(8'($urandom), 1'b1, 1'b0);
      send_request(8'($urandom), 1'b0, (i == len - 1));
    end
    if (len == 0) send_request(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    int lens[$];
    sb = new();
    err_count = 0;
    n_sent = 0;
    send_idle_pct = 19;
    recv_idle_pct = 76;
    hold_cycles = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    msg_byte = '0;
    no_byte = 1'b0;
    msg_last = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty message, lone bytes at extremes, empty items
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hff, 1'b1, 1'b1);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hff, 1'b0, 1'b1);
    send_request(8'h55, 1'b0, 1'b0);
    send_request(8'haa, 1'b1, 1'b1);
    drain();

    // one-block tail, two-block tails and a block boundary ending
    lens = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i], 1'b0);
    drain();

    // long receiver hold-off while short messages pile up behind the engine
    hold_cycles = 400;
    for (int m = 0; m < 8; m++) send_message(1, 1'b0);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 76 : 0;
      recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 19 : 0;
      while (n_sent < 290 + 35 * phase)
        send_message($urandom_range(20), 1'b1);
      drain();
    end
    repeat (200) @(negedge clk);

    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
